[rtl/assert_macros.svh]
// Assertion macros used by the port checker.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

[rtl/khu_pkg.sv]
// Package for the key name to HID usage lookup: types, codes and the name ROM.
// No dependencies.
package khu_pkg;

    localparam int ROM_COUNT = 52;
    localparam int ROM_WIDTH = 12;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [7:0] LETTER_OFFSET = 8'h5D;  // 'a' - 0x04
    localparam logic [7:0] DIGIT_OFFSET  = 8'h13;  // '1' - 0x1E
    localparam logic [7:0] DIGIT_ZERO    = 8'h27;
    localparam logic [7:0] FKEY_LO_OFS   = 8'h39;  // 0x3A - 1
    localparam logic [7:0] FKEY_HI_OFS   = 8'h5B;  // 0x68 - 13
    localparam logic [6:0] FKEY_MAX      = 7'd24;
    localparam logic [6:0] FKEY_SPLIT    = 7'd12;

    localparam logic [7:0] DIGIT_WORD [5] = '{8'h64, 8'h69, 8'h67, 8'h69, 8'h74};

    localparam logic [ROM_WIDTH*8-1:0] ROM_TEXT [ROM_COUNT] = '{
        "enter", "return", "esc", "escape", "backspace", "tab", "space", "minus",
        "equal", "lbracket", "rbracket", "backslash", "semicolon", "quote", "grave",
        "comma", "period", "slash", "capslock", "printscreen", "scrolllock", "pause",
        "insert", "home", "pageup", "delete", "end", "pagedown", "right", "left",
        "down", "up", "numlock", "lctrl", "lshift", "lalt", "lgui", "rctrl", "rshift",
        "ralt", "rgui", "ctrl", "control", "shift", "alt", "gui", "win", "meta",
        "super", "lwin", "rwin", "menu"
    };

    localparam logic [3:0] ROM_LEN [ROM_COUNT] = '{
        4'd5, 4'd6, 4'd3, 4'd6, 4'd9, 4'd3, 4'd5, 4'd5,
        4'd5, 4'd8, 4'd8, 4'd9, 4'd9, 4'd5, 4'd5,
        4'd5, 4'd6, 4'd5, 4'd8, 4'd11, 4'd10, 4'd5,
        4'd6, 4'd4, 4'd6, 4'd6, 4'd3, 4'd8, 4'd5, 4'd4,
        4'd4, 4'd2, 4'd7, 4'd5, 4'd6, 4'd4, 4'd4, 4'd5, 4'd6,
        4'd4, 4'd4, 4'd4, 4'd7, 4'd5, 4'd3, 4'd3, 4'd3, 4'd4,
        4'd5, 4'd4, 4'd4, 4'd4
    };

    localparam logic [7:0] ROM_CODE [ROM_COUNT] = '{
        8'h28, 8'h28, 8'h29, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D,
        8'h2E, 8'h2F, 8'h30, 8'h31, 8'h33, 8'h34, 8'h35,
        8'h36, 8'h37, 8'h38, 8'h39, 8'h46, 8'h47, 8'h48,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
        8'h51, 8'h52, 8'h53, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5,
        8'hE6, 8'hE7, 8'hE0, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE3, 8'hE3,
        8'hE3, 8'hE3, 8'hE7, 8'h65
    };

    typedef struct packed {
        logic [7:0] name_char;
        logic       name_last;
    } khu_item_t;

    typedef struct packed {
        logic       found;
        logic [7:0] usage_code;
    } khu_res_t;

    // Character of entry e at position q; zero past the end of the name.
    function automatic logic [7:0] rom_char(input int e, input int q);
        logic [ROM_WIDTH*8-1:0] t;
        int                     n;
        t = ROM_TEXT[e];
        n = int'(ROM_LEN[e]);
        if (q >= n) begin
            return 8'h00;
        end
        return t[(n - 1 - q)*8 +: 8];
    endfunction

endpackage

[rtl/khu_match.sv]
// Per-name matching state and result logic for the key name lookup.
// Depends on khu_pkg.
module khu_match
    import khu_pkg::*;
#(
    parameter int TABLE_ENTRIES = 52,
    parameter int MAX_NAME      = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  khu_item_t item,
    output khu_res_t  res
);

    localparam int ENTRY_COUNT = (TABLE_ENTRIES < ROM_COUNT) ? TABLE_ENTRIES : ROM_COUNT;
    localparam int POS_W       = $clog2(MAX_NAME + 1);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [ENTRY_COUNT-1:0] mask_reg, mask_next;
    logic                   dig_ok_reg, dig_ok_next;
    logic [6:0]             fk_num_reg, fk_num_next;
    logic                   fk_ok_reg, fk_ok_next;

    logic [7:0]  b;
    logic [7:0]  lc;
    logic        is_dec;
    logic        too_long;
    logic [10:0] fk_prod;
    logic [ENTRY_COUNT-1:0] hit_vec;
    logic [7:0]  rom_code;

    always_comb
    begin
        logic [7:0] expect_c;
        logic       keep;
        b        = item.name_char;
        lc       = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? (b | CASE_BIT) : b;
        is_dec   = (b >= CH_ZERO) && (b <= CH_NINE);
        too_long = pos_reg >= POS_W'(MAX_NAME);
        pos_next = too_long ? pos_reg : pos_reg + 1'b1;

        fk_prod     = 11'(fk_num_reg) * 11'd10 + 11'(b[3:0]);
        fk_num_next = fk_num_reg;
        fk_ok_next  = fk_ok_reg;
        if (pos_reg == '0)
        begin
            fk_ok_next  = (lc == CH_LOWER_F);
            fk_num_next = '0;
        end
        else if (pos_reg == POS_W'(1) || pos_reg == POS_W'(2))
        begin
            if (is_dec && !(pos_reg == POS_W'(1) && b == CH_ZERO))
            begin
                fk_num_next = fk_prod[6:0];
            end
            else
            begin
                fk_ok_next = 1'b0;
            end
        end
        else
        begin
            fk_ok_next = 1'b0;
        end

        dig_ok_next = dig_ok_reg;
        for (int q = 0; q < 5; q++)
        begin
            if (pos_reg == POS_W'(q) && lc != DIGIT_WORD[q])
            begin
                dig_ok_next = 1'b0;
            end
        end

        rom_code = '0;
        for (int e = 0; e < ENTRY_COUNT; e++)
        begin
            expect_c = 8'h00;
            for (int q = 0; q < ROM_WIDTH; q++)
            begin
                if (pos_reg == POS_W'(q))
                begin
                    expect_c = rom_char(e, q);
                end
            end
            keep = (pos_reg >= POS_W'(ROM_LEN[e])) || (expect_c == lc);
            mask_next[e] = mask_reg[e] & keep;
            hit_vec[e]   = mask_next[e] && (pos_reg == POS_W'(ROM_LEN[e] - 4'd1));
            rom_code     = rom_code | (hit_vec[e] ? ROM_CODE[e] : 8'h00);
        end

        res = '0;
        if (too_long)
        begin
            res = '0;
        end
        else if (pos_reg == '0)
        begin
            if (lc >= CH_LOWER_A && lc <= CH_LOWER_Z)
            begin
                res.found      = 1'b1;
                res.usage_code = lc - LETTER_OFFSET;
            end
        end
        else if (pos_reg == POS_W'(5) && dig_ok_reg && is_dec)
        begin
            res.found      = 1'b1;
            res.usage_code = (b == CH_ZERO) ? DIGIT_ZERO : b - DIGIT_OFFSET;
        end
        else if (fk_ok_next && (pos_reg == POS_W'(1) || pos_reg == POS_W'(2))
                 && fk_num_next >= 7'd1 && fk_num_next <= FKEY_MAX)
        begin
            res.found      = 1'b1;
            res.usage_code = (fk_num_next <= FKEY_SPLIT)
                           ? FKEY_LO_OFS + 8'(fk_num_next)
                           : FKEY_HI_OFS + 8'(fk_num_next);
        end
        else
        begin
            res.found      = |hit_vec;
            res.usage_code = rom_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            mask_reg   <= '1;
            dig_ok_reg <= 1'b1;
            fk_num_reg <= '0;
            fk_ok_reg  <= 1'b1;
        end
        else if (fire)
        begin
            if (item.name_last)
            begin
                pos_reg    <= '0;
                mask_reg   <= '1;
                dig_ok_reg <= 1'b1;
                fk_num_reg <= '0;
                fk_ok_reg  <= 1'b1;
            end
            else
            begin
                pos_reg    <= pos_next;
                mask_reg   <= mask_next;
                dig_ok_reg <= dig_ok_next;
                fk_num_reg <= fk_num_next;
                fk_ok_reg  <= fk_ok_next;
            end
        end
    end

endmodule

[rtl/key_name_to_hid_usage_top.sv]
// Top level of the key name to HID usage lookup: input register, matcher, output register.
// Depends on khu_pkg and khu_match.
//
// Usage:
//   Slave stream s_*: one name byte per transfer in s_tdata, s_tlast on the final byte.
//   Master stream m_*: one result per name, m_tuser = found, m_tdata = usage code
//   (zero when not found).
//   Each byte is held in the input register, then matched combinationally against the
//   running per-name state; a result enters the output register on the cycle the final
//   byte is matched.
//   Throughput: one byte per cycle, except while a final byte waits for the output register.
//   Reset clears the valid flags of both registers and the per-name state; the next byte starts a new name.
//   When the receiver stalls, non-final bytes keep flowing; a final byte waits in the
//   input register until the output register is free, and s_tready drops behind it.
module key_name_to_hid_usage_top
    import khu_pkg::*;
#(
    parameter int TABLE_ENTRIES = 52,
    parameter int MAX_NAME      = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] name_char
    input  logic       s_tlast,   // name_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] usage_code
    output logic       m_tuser    // [0] found
);

    logic      in_valid_reg;
    khu_item_t in_item_reg;
    logic      out_valid_reg;
    khu_res_t  out_res_reg;
    khu_res_t  match_res;
    logic      out_free;
    logic      fire;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_item_reg.name_last || out_free);
    assign s_tready = !in_valid_reg || fire;

    khu_match #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_NAME      (MAX_NAME)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_item_reg),
        .res   (match_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire && in_item_reg.name_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.name_char <= s_tdata;
            in_item_reg.name_last <= s_tlast;
        end
        if (fire && in_item_reg.name_last)
        begin
            out_res_reg <= match_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.usage_code;
    assign m_tuser  = out_res_reg.found;

endmodule

[rtl/khu_checker.sv]
// Port-level checker for the key name lookup, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module khu_port_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    logic last_xfer;
    logic out_stall;

    assign last_xfer = s_tvalid && s_tready && s_tlast;
    assign out_stall = m_tvalid && !m_tready;

    `ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_SAME(a_miss_zero, m_tvalid && !m_tuser, m_tdata == 8'h00)
    `ASSERT_SAME(a_hit_nonzero, m_tvalid && m_tuser, m_tdata != 8'h00)
    `ASSERT_SAME(a_res_after_last, $rose(m_tvalid), $past(last_xfer, 2) || $past(!s_tready))

endmodule

bind key_name_to_hid_usage_top khu_port_checker u_khu_checker (.*);

[tb/sv/khu_checker.sv]
`timescale 1ns / 1ps
// Checker for key_name_to_hid_usage_top: watches both stream channels, predicts the
// lookup result of every name and compares it with each output transfer. Needs khu_pkg.
module khu_checker
    import khu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    output int         errors,
    output int         pending
);

    localparam int NAME_MAX  = 16;
    localparam int KEY_COUNT = 52;
    localparam int KEY_WIDTH = 12;
    localparam int REPORT_MAX = 10;

    localparam logic [7:0] LETTER_BASE     = 8'h04;
    localparam logic [7:0] DIGIT_BASE      = 8'h1E;
    localparam logic [7:0] DIGIT_ZERO_CODE = 8'h27;
    localparam logic [7:0] FKEY_LO_BASE    = 8'h3A;
    localparam logic [7:0] FKEY_HI_BASE    = 8'h68;
    localparam logic [6:0] FKEY_LO_TOP     = 7'd12;
    localparam logic [6:0] FKEY_TOP        = 7'd24;

    string key_text [KEY_COUNT] = '{
        "enter", "return", "esc", "escape", "backspace", "tab", "space", "minus",
        "equal", "lbracket", "rbracket", "backslash", "semicolon", "quote", "grave",
        "comma", "period", "slash", "capslock", "printscreen", "scrolllock", "pause",
        "insert", "home", "pageup", "delete", "end", "pagedown", "right", "left",
        "down", "up", "numlock", "lctrl", "lshift", "lalt", "lgui", "rctrl", "rshift",
        "ralt", "rgui", "ctrl", "control", "shift", "alt", "gui", "win", "meta",
        "super", "lwin", "rwin", "menu"
    };

    logic [7:0] key_code [KEY_COUNT] = '{
        8'h28, 8'h28, 8'h29, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D,
        8'h2E, 8'h2F, 8'h30, 8'h31, 8'h33, 8'h34, 8'h35,
        8'h36, 8'h37, 8'h38, 8'h39, 8'h46, 8'h47, 8'h48,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
        8'h51, 8'h52, 8'h53, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5,
        8'hE6, 8'hE7, 8'hE0, 8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE3, 8'hE3,
        8'hE3, 8'hE3, 8'hE7, 8'h65
    };

    string digit_word = "digit";

    logic [4:0]           name_pos;
    logic [KEY_COUNT-1:0] name_cand;
    logic [7:0]           name_first;
    logic                 digit_ok;
    logic [6:0]           fkey_val;
    logic                 fkey_ok;

    khu_res_t usage_q [$];
    int       fail_cnt = 0;
    int       wait_cnt = 0;
    int       res_cnt  = 0;

    assign errors  = fail_cnt;
    assign pending = wait_cnt;

    function automatic void clear_name();
        name_pos   = '0;
        name_cand  = '1;
        name_first = '0;
        digit_ok   = 1'b1;
        fkey_val   = '0;
        fkey_ok    = 1'b1;
    endfunction

    // Advances the per-name state by one byte; returns 1 with the lookup on the final byte.
    function automatic bit name_step(input logic [7:0] ch, input logic last,
                                     output khu_res_t res);
        logic [7:0] lc;
        logic [7:0] rc;
        logic       is_num;
        logic       too_long;
        int         p;
        int         len;
        res      = '0;
        lc       = (ch >= "A" && ch <= "Z") ? (ch | 8'h20) : ch;
        is_num   = ch >= "0" && ch <= "9";
        p        = int'(name_pos);
        too_long = p >= NAME_MAX;

        if (p == 0)
        begin
            name_first = lc;
            fkey_ok    = (lc == "f");
            fkey_val   = '0;
        end
        else if (p <= 2)
        begin
            if (is_num && !(p == 1 && ch == "0"))
                fkey_val = 7'(int'(fkey_val) * 10 + int'(ch - "0"));
            else
                fkey_ok = 1'b0;
        end
        else
        begin
            fkey_ok = 1'b0;
        end

        if (p < 5 && lc != digit_word[p])
            digit_ok = 1'b0;

        for (int e = 0; e < KEY_COUNT; e++)
        begin
            rc = (p < key_text[e].len()) ? key_text[e][p] : 8'h00;
            if (p >= KEY_WIDTH || lc != rc)
                name_cand[e] = 1'b0;
        end

        if (!too_long)
            name_pos = name_pos + 5'd1;

        if (!last)
            return 1'b0;

        len = p + 1;
        if (too_long)
        begin
            res = '0;
        end
        else if (len == 1)
        begin
            if (name_first >= "a" && name_first <= "z")
            begin
                res.found      = 1'b1;
                res.usage_code = LETTER_BASE + (name_first - "a");
            end
        end
        else if (len == 6 && digit_ok && is_num)
        begin
            res.found      = 1'b1;
            res.usage_code = (ch == "0") ? DIGIT_ZERO_CODE : DIGIT_BASE + (ch - "1");
        end
        else if (fkey_ok && (len == 2 || len == 3) && fkey_val >= 7'd1 && fkey_val <= FKEY_TOP)
        begin
            res.found      = 1'b1;
            res.usage_code = (fkey_val <= FKEY_LO_TOP)
                           ? FKEY_LO_BASE + 8'(fkey_val) - 8'd1
                           : FKEY_HI_BASE + 8'(fkey_val - FKEY_LO_TOP) - 8'd1;
        end
        else
        begin
            for (int e = 0; e < KEY_COUNT && !res.found; e++)
            begin
                if (name_cand[e] && key_text[e].len() == len)
                begin
                    res.found      = 1'b1;
                    res.usage_code = key_code[e];
                end
            end
        end

        clear_name();
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        khu_res_t got;
        khu_res_t want;
        if (!rst_n)
        begin
            clear_name();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.found      = m_tuser;
                got.usage_code = m_tdata;
                if (usage_q.size() == 0)
                begin
                    if (fail_cnt < REPORT_MAX)
                        $display("%0t: result %0d found=%0b code=%02h with none expected",
                                 $time, res_cnt, got.found, got.usage_code);
                    fail_cnt++;
                end
                else
                begin
                    want = usage_q.pop_front();
                    if (got.found !== want.found || got.usage_code !== want.usage_code)
                    begin
                        if (fail_cnt < REPORT_MAX)
                            $display("%0t: result %0d mismatch: found=%0b/%0b code=%02h/%02h (exp/act)",
                                     $time, res_cnt, want.found, got.found,
                                     want.usage_code, got.usage_code);
                        fail_cnt++;
                    end
                end
                res_cnt++;
            end
            if (s_tvalid && s_tready)
            begin
                if (name_step(s_tdata, s_tlast, want))
                    usage_q.push_back(want);
            end
            wait_cnt = usage_q.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench top for key_name_to_hid_usage_top: sends directed and random key names,
// idles both streams and gives the verdict. Needs khu_pkg, the block and khu_checker.
module tb;
    import khu_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BYTE_TARGET    = 1250;
    localparam int IDLE_PCT       = 36;
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int STEADY_FIRST   = 120;
    localparam int STEADY_LAST    = 180;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] name_char
    logic       s_tlast;   // name_last
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] usage_code
    logic       m_tuser;   // [0] found

    int errors;
    int pending;
    int bytes_sent = 0;
    int names_sent = 0;
    int quiet      = 0;
    bit steady     = 1'b0;
    bit held       = 1'b0;

    logic [7:0] name_bytes [$];

    string directed_names [22] = '{
        "a", "Z", "m", "1", "digit1", "DIGIT0", "DiGiT9", "digitx", "f1", "F12", "f13",
        "f24", "f25", "f0", "f01", "enter", "ESC", "Menu", "up", "printscreen",
        "abcdefghijklmnop", "abcdefghijklmnopq"
    };

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    key_name_to_hid_usage_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    khu_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    function automatic logic [7:0] any_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
            return c ^ 8'h20;
        return c;
    endfunction

    function automatic void add_text(input string txt, input bit mix);
        for (int i = 0; i < txt.len(); i++)
            name_bytes.push_back(mix ? any_case(txt[i]) : txt[i]);
    endfunction

    // One byte per transfer, tlast on the final one.
    task automatic send_name();
        int i;
        for (i = 0; i < name_bytes.size(); i++)
        begin
            while (!steady && $urandom_range(99) < IDLE_PCT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= name_bytes[i];
            s_tlast  <= (i == name_bytes.size() - 1);
            do @(posedge clk); while (!s_tready);
            bytes_sent++;
        end
        name_bytes.delete();
        names_sent++;
        steady = names_sent >= STEADY_FIRST && names_sent < STEADY_LAST;
    endtask

    // Mostly well-formed names of every kind, some broken, some plain noise.
    task automatic make_random_name();
        int kind;
        int n;
        int e;
        int len;
        int q;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            if ($urandom_range(99) < 70)
                name_bytes.push_back(any_case(8'($urandom_range(8'h7A, 8'h61))));
            else
                name_bytes.push_back(8'($urandom_range(255)));
        end
        else if (kind < 22)
        begin
            add_text("digit", 1'b1);
            if ($urandom_range(9) == 0)
                name_bytes[$urandom_range(4)] = 8'($urandom_range(255));
            if ($urandom_range(9) == 0)
                name_bytes.push_back(8'($urandom_range(255)));
            else
                name_bytes.push_back(8'h30 + 8'($urandom_range(9)));
        end
        else if (kind < 38)
        begin
            name_bytes.push_back(any_case("f"));
            n = $urandom_range(30);
            if ($urandom_range(9) == 0)
                name_bytes.push_back("0");
            if (n >= 10)
                name_bytes.push_back(8'h30 + 8'(n / 10));
            name_bytes.push_back(8'h30 + 8'(n % 10));
            if ($urandom_range(19) == 0)
                name_bytes.push_back(8'h30 + 8'($urandom_range(9)));
        end
        else if (kind < 78)
        begin
            e   = $urandom_range(ROM_COUNT - 1);
            len = int'(ROM_LEN[e]);
            for (q = 0; q < len; q++)
                name_bytes.push_back(any_case(ROM_TEXT[e][(len - 1 - q) * 8 +: 8]));
            case ($urandom_range(7))
                0: name_bytes[$urandom_range(len - 1)] = 8'($urandom_range(255));
                1: void'(name_bytes.pop_back());
                2: name_bytes.push_back(any_case(8'($urandom_range(8'h7A, 8'h61))));
                default: ;
            endcase
        end
        else if (kind < 92)
        begin
            len = $urandom_range(12, 1);
            repeat (len) name_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            len = $urandom_range(20, 14);
            repeat (len) name_bytes.push_back(any_case(8'($urandom_range(8'h7A, 8'h61))));
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_names[i])
        begin
            add_text(directed_names[i], 1'b0);
            send_name();
        end
        name_bytes = '{8'h00};
        send_name();
        name_bytes = '{8'hFF};
        send_name();
        add_text("end", 1'b0);
        name_bytes.push_back(8'h00);
        send_name();

        while (bytes_sent < BYTE_TARGET)
        begin
            make_random_name();
            send_name();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("[key_name_to_hid_usage_top] OK");
        else
            $display("[key_name_to_hid_usage_top] ERROR");
        $finish;
    end

    // Receiver; one long hold-off lets the block fill up and stall its input.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held && names_sent >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("[key_name_to_hid_usage_top] ERROR");
                $finish;
            end
        end
    end

endmodule
